// ===== hw/rtl/b58enc_pkg.sv =====
// Shared types, constants and helper functions for the Base58 encoder.
// No dependencies; used by every other file of the block.
package b58enc_pkg;

    localparam int MAX_BYTES   = 32;
    localparam int BUF_AW      = 5;
    localparam int DIGIT_DEPTH = 44;

    localparam logic [6:0] RESULT_LIMIT = 7'd44;
    localparam logic [5:0] ZERO_SAT     = 6'd63;

    // floor(t / 58) for t < 14848 as (t * DIV_RECIP) >> DIV_SHIFT
    localparam logic [28:0] DIV_RECIP = 29'd18079;
    localparam int          DIV_SHIFT = 20;
    localparam logic [13:0] RADIX     = 14'd58;

    // floor(n * 183 / 134) for n <= 32 as (n * EST_MUL) >> EST_SHIFT
    localparam logic [31:0] EST_MUL   = 32'd91648779;
    localparam int          EST_SHIFT = 26;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CAPACITY = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic REG_MAX_CHARS = 1'b0;
    localparam logic [5:0] MAX_CHARS_RESET = 6'd63;

    localparam logic [6:0] CHAR_ONE = 7'h31;

    localparam logic [6:0] B58_ALPHABET [64] = '{
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
        7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
        7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E,
        7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
        7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6A, 7'h6B,
        7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77,
        7'h78, 7'h79, 7'h7A,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_TOTAL,
        ST_EMIT_ONE,
        ST_EMIT_RD,
        ST_EMIT_DIG,
        ST_ERROR
    } seq_state_t;

    typedef struct packed {
        logic       load;
        logic [6:0] char_code;
        logic       last_char;
        logic [1:0] status;
    } seq_out_t;

    function automatic logic [5:0] est_digits(input logic [5:0] n);
        logic [31:0] p;
        p = 32'(n) * EST_MUL;
        return 6'(p >> EST_SHIFT);
    endfunction

endpackage

// ===== hw/rtl/b58enc_div58.sv =====
// One long-division step by 58: (remainder, byte) in, quotient byte and new remainder out.
// Depends on b58enc_pkg.
module b58enc_div58 (
    input  logic [5:0] rem_in,
    input  logic [7:0] byte_in,
    output logic [7:0] quot,
    output logic [5:0] rem_out
);

    logic [13:0] t;
    logic [28:0] prod;
    logic [13:0] back;
    logic [13:0] diff;

    assign t       = {rem_in, byte_in};
    assign prod    = 29'(t) * b58enc_pkg::DIV_RECIP;
    assign quot    = 8'(prod >> b58enc_pkg::DIV_SHIFT);
    assign back    = 14'(quot) * b58enc_pkg::RADIX;
    assign diff    = t - back;
    assign rem_out = diff[5:0];

endmodule

// ===== hw/rtl/b58enc_seq.sv =====
// Sequencer: byte intake, number buffer, repeated division passes, digit store, emission.
// Depends on b58enc_pkg and b58enc_div58.
module b58enc_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [7:0]            s_data,
    input  logic                  s_last,
    output logic                  s_ready,
    input  logic [5:0]            max_chars,
    input  logic                  out_free,
    output b58enc_pkg::seq_out_t  seq_out
);

    b58enc_pkg::seq_state_t state_reg, state_next;

    logic [5:0] byte_cnt_reg, byte_cnt_next;
    logic [5:0] lzc_reg, lzc_next;
    logic       zero_run_reg, zero_run_next;
    logic       ovf_reg, ovf_next;
    logic [5:0] size_reg, size_next;
    logic [5:0] pass_reg, pass_next;
    logic [4:0] idx_reg, idx_next;
    logic [5:0] rem_reg, rem_next;
    logic [5:0] ndig_reg, ndig_next;
    logic [5:0] zeros_left_reg, zeros_left_next;
    logic [5:0] dig_idx_reg, dig_idx_next;
    logic [1:0] err_code_reg, err_code_next;

    logic [7:0] buf_mem [b58enc_pkg::MAX_BYTES];
    logic [7:0] buf_rdata_reg;
    logic       buf_we;
    logic [b58enc_pkg::BUF_AW-1:0] buf_waddr, buf_raddr;
    logic [7:0] buf_wdata;

    logic [5:0] dig_mem [b58enc_pkg::DIGIT_DEPTH];
    logic [5:0] dig_rdata_reg;
    logic       dig_we;

    logic [7:0] quot;
    logic [5:0] rem_out;
    logic [6:0] total;

    b58enc_div58 u_div58 (
        .rem_in  (rem_reg),
        .byte_in (buf_rdata_reg),
        .quot    (quot),
        .rem_out (rem_out)
    );

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_waddr] <= buf_wdata;
        end
        buf_rdata_reg <= buf_mem[buf_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dig_we) begin
            dig_mem[pass_reg] <= rem_out;
        end
        dig_rdata_reg <= dig_mem[dig_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= b58enc_pkg::ST_IDLE;
            byte_cnt_reg <= '0;
            lzc_reg      <= '0;
            zero_run_reg <= 1'b1;
            ovf_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
            lzc_reg      <= lzc_next;
            zero_run_reg <= zero_run_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        pass_reg       <= pass_next;
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        ndig_reg       <= ndig_next;
        zeros_left_reg <= zeros_left_next;
        dig_idx_reg    <= dig_idx_next;
        err_code_reg   <= err_code_next;
    end

    assign s_ready = (state_reg == b58enc_pkg::ST_IDLE);
    assign total   = 7'(lzc_reg) + 7'(ndig_reg);

    always_comb begin
        state_next      = state_reg;
        byte_cnt_next   = byte_cnt_reg;
        lzc_next        = lzc_reg;
        zero_run_next   = zero_run_reg;
        ovf_next        = ovf_reg;
        size_next       = size_reg;
        pass_next       = pass_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        ndig_next       = ndig_reg;
        zeros_left_next = zeros_left_reg;
        dig_idx_next    = dig_idx_reg;
        err_code_next   = err_code_reg;
        buf_we          = 1'b0;
        buf_waddr       = idx_reg;
        buf_wdata       = quot;
        buf_raddr       = '0;
        dig_we          = 1'b0;
        seq_out         = '0;

        unique case (state_reg)
            b58enc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (zero_run_reg && s_data == 8'd0) begin
                        if (lzc_reg != b58enc_pkg::ZERO_SAT) begin
                            lzc_next = lzc_reg + 6'd1;
                        end
                    end else begin
                        zero_run_next = 1'b0;
                        if (byte_cnt_reg < 6'(b58enc_pkg::MAX_BYTES)) begin
                            buf_we        = 1'b1;
                            buf_waddr     = byte_cnt_reg[b58enc_pkg::BUF_AW-1:0];
                            buf_wdata     = s_data;
                            byte_cnt_next = byte_cnt_reg + 6'd1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_last) begin
                        if (ovf_next) begin
                            err_code_next = b58enc_pkg::STATUS_OVERFLOW;
                            state_next    = b58enc_pkg::ST_ERROR;
                        end else begin
                            state_next = b58enc_pkg::ST_CALC;
                        end
                    end
                end
            end
            b58enc_pkg::ST_CALC: begin
                size_next  = b58enc_pkg::est_digits(byte_cnt_reg) + 6'd1;
                state_next = b58enc_pkg::ST_CHECK;
            end
            b58enc_pkg::ST_CHECK: begin
                pass_next = '0;
                ndig_next = '0;
                if (7'(lzc_reg) + 7'(size_reg) > 7'(max_chars)) begin
                    err_code_next = b58enc_pkg::STATUS_CAPACITY;
                    state_next    = b58enc_pkg::ST_ERROR;
                end else if (byte_cnt_reg == 6'd0) begin
                    state_next = b58enc_pkg::ST_TOTAL;
                end else begin
                    state_next = b58enc_pkg::ST_DIV_START;
                end
            end
            b58enc_pkg::ST_DIV_START: begin
                buf_raddr  = '0;
                rem_next   = '0;
                idx_next   = '0;
                state_next = b58enc_pkg::ST_DIV_RUN;
            end
            b58enc_pkg::ST_DIV_RUN: begin
                buf_we    = 1'b1;
                buf_waddr = idx_reg;
                buf_wdata = quot;
                rem_next  = rem_out;
                buf_raddr = idx_reg + 5'd1;
                if (6'(idx_reg) + 6'd1 == byte_cnt_reg) begin
                    dig_we = 1'b1;
                    if (rem_out != 6'd0) begin
                        ndig_next = pass_reg + 6'd1;
                    end
                    if (pass_reg == size_reg - 6'd1) begin
                        state_next = b58enc_pkg::ST_TOTAL;
                    end else begin
                        pass_next  = pass_reg + 6'd1;
                        state_next = b58enc_pkg::ST_DIV_START;
                    end
                end else begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            b58enc_pkg::ST_TOTAL: begin
                zeros_left_next = lzc_reg;
                dig_idx_next    = ndig_reg - 6'd1;
                if (total > b58enc_pkg::RESULT_LIMIT) begin
                    err_code_next = b58enc_pkg::STATUS_CAPACITY;
                    state_next    = b58enc_pkg::ST_ERROR;
                end else if (lzc_reg != 6'd0) begin
                    state_next = b58enc_pkg::ST_EMIT_ONE;
                end else begin
                    state_next = b58enc_pkg::ST_EMIT_RD;
                end
            end
            b58enc_pkg::ST_EMIT_ONE: begin
                if (out_free) begin
                    seq_out.load      = 1'b1;
                    seq_out.char_code = b58enc_pkg::CHAR_ONE;
                    seq_out.last_char = (zeros_left_reg == 6'd1) && (ndig_reg == 6'd0);
                    seq_out.status    = b58enc_pkg::STATUS_OK;
                    zeros_left_next   = zeros_left_reg - 6'd1;
                    if (zeros_left_reg == 6'd1) begin
                        if (ndig_reg == 6'd0) begin
                            byte_cnt_next = '0;
                            lzc_next      = '0;
                            zero_run_next = 1'b1;
                            ovf_next      = 1'b0;
                            state_next    = b58enc_pkg::ST_IDLE;
                        end else begin
                            state_next = b58enc_pkg::ST_EMIT_RD;
                        end
                    end
                end
            end
            b58enc_pkg::ST_EMIT_RD: begin
                state_next = b58enc_pkg::ST_EMIT_DIG;
            end
            b58enc_pkg::ST_EMIT_DIG: begin
                if (out_free) begin
                    seq_out.load      = 1'b1;
                    seq_out.char_code = b58enc_pkg::B58_ALPHABET[dig_rdata_reg];
                    seq_out.last_char = (dig_idx_reg == 6'd0);
                    seq_out.status    = b58enc_pkg::STATUS_OK;
                    if (dig_idx_reg == 6'd0) begin
                        byte_cnt_next = '0;
                        lzc_next      = '0;
                        zero_run_next = 1'b1;
                        ovf_next      = 1'b0;
                        state_next    = b58enc_pkg::ST_IDLE;
                    end else begin
                        dig_idx_next = dig_idx_reg - 6'd1;
                        state_next   = b58enc_pkg::ST_EMIT_RD;
                    end
                end
            end
            b58enc_pkg::ST_ERROR: begin
                if (out_free) begin
                    seq_out.load      = 1'b1;
                    seq_out.char_code = '0;
                    seq_out.last_char = 1'b1;
                    seq_out.status    = err_code_reg;
                    byte_cnt_next     = '0;
                    lzc_next          = '0;
                    zero_run_next     = 1'b1;
                    ovf_next          = 1'b0;
                    state_next        = b58enc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = b58enc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/base58_encoder.sv =====
// Base58 (Bitcoin alphabet) encoder: top level with register port and output register.
// Depends on b58enc_pkg and b58enc_seq.
//
// Bytes of one big-endian string are taken one per cycle while s_tready is high; the
// byte with tlast closes the string and s_tready then stays low until its last result
// has been loaded into the output register. Leading zero bytes are only counted; up to
// 32 further bytes are kept. With n kept bytes and size = n*183/134 + 1, the single
// divide-by-58 step unit walks the buffer once per digit, one byte per cycle, with a
// restart state before each pass. Characters follow at one per cycle for each leading
// '1' while the output register can take them; each of the other digits first passes
// a read state before it is loaded. A string that does not fit max_chars (or 44
// characters), or that has more than 32 bytes after its zero run, gives one result with
// char 0 and a non-zero status instead.
module base58_encoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [6:0] char_code, [7] zero
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // [1:0] status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0] max_chars_reg;
    logic       m_valid_reg;
    logic [6:0] m_char_reg;
    logic       m_last_reg;
    logic [1:0] m_status_reg;
    logic       out_free;

    b58enc_pkg::seq_out_t seq_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == b58enc_pkg::REG_MAX_CHARS) ? 32'(max_chars_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= b58enc_pkg::MAX_CHARS_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == b58enc_pkg::REG_MAX_CHARS) begin
            max_chars_reg <= pwdata[5:0];
        end
    end

    b58enc_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_data    (s_tdata),
        .s_last    (s_tlast),
        .s_ready   (s_tready),
        .max_chars (max_chars_reg),
        .out_free  (out_free),
        .seq_out   (seq_out)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (seq_out.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_out.load) begin
            m_char_reg   <= seq_out.char_code;
            m_last_reg   <= seq_out.last_char;
            m_status_reg <= seq_out.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

endmodule

// ===== hw/rtl/b58enc_checker.sv =====
// Port-level checks for the Base58 encoder, bound to the top level.
// Depends on b58enc_pkg and base58_encoder.
module b58enc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // error transaction: single, last, no character
    a_error_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != b58enc_pkg::STATUS_OK |-> m_tlast && m_tdata == 8'd0)
        else $error("error result not a lone closing transaction");

    a_ok_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == b58enc_pkg::STATUS_OK |-> m_tdata != 8'd0 && !m_tdata[7])
        else $error("ok result without a character");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == b58enc_pkg::STATUS_OK || m_tuser == b58enc_pkg::STATUS_CAPACITY
                     || m_tuser == b58enc_pkg::STATUS_OVERFLOW)
        else $error("unknown status");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken while a string is being encoded");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result dropped or changed");

endmodule

bind base58_encoder b58enc_checker u_b58enc_checker (.*);
